/* hdl/msm_pkg.sv */
`default_nettype none

package msm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 24;
    localparam int GAIN_FRAC   = 20;
    localparam int COEFF_BITS  = 25;
    localparam int CLIP_BITS   = 32;
    localparam int CNT_BITS    = 2;

    localparam int GPROD_BITS = GAIN_BITS + COEFF_BITS;
    localparam int MPROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int MSUM_BITS  = MPROD_BITS + 1;

    localparam int IN_DATA_BITS   = ((4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * SAMPLE_BITS + CNT_BITS + CLIP_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int ADDR_BITS     = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] REG_PRI_TARGET = 2'd0;
    localparam logic [1:0] REG_SEC_TARGET = 2'd1;
    localparam logic [1:0] REG_COEFF      = 2'd2;

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC;
    localparam logic [COEFF_BITS-1:0] COEFF_ONE  = COEFF_BITS'(1) << (COEFF_BITS - 1);
    localparam logic [GPROD_BITS-1:0] GAIN_HALF  = GPROD_BITS'(1) << (COEFF_BITS - 2);

    localparam logic signed [MSUM_BITS-1:0] MIX_HALF = MSUM_BITS'(1) << (GAIN_FRAC - 1);
    localparam logic signed [MSUM_BITS-1:0] MIX_MAX  =
        (MSUM_BITS'(1) << (SAMPLE_BITS - 1)) - MSUM_BITS'(1);
    localparam logic signed [MSUM_BITS-1:0] MIX_MIN  = -MIX_MAX - MSUM_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [GAIN_BITS-1:0]          t_gain;
    typedef logic [COEFF_BITS-1:0]         t_coeff;

    typedef struct packed {
        logic gain_mul;
        logic gain_upd;
        logic mix_mul;
        logic mix_sum;
        logic merge_load;
    } t_step_ctl;

endpackage

`default_nettype wire

/* hdl/msm_gain_lane.sv */
`default_nettype none

module msm_gain_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire msm_pkg::t_step_ctl i_ctl,
    input  wire msm_pkg::t_gain     i_goal,
    input  wire msm_pkg::t_coeff    i_coeff,
    output msm_pkg::t_gain          o_gain
);

    logic [msm_pkg::GPROD_BITS-1:0] r_prod, n_prod;
    logic                           r_up, n_up;
    msm_pkg::t_gain                 r_gain, n_gain;
    msm_pkg::t_gain                 w_mag;
    logic [msm_pkg::GPROD_BITS-1:0] w_round;
    msm_pkg::t_gain                 w_step;

    always_comb begin
        n_up    = (i_goal >= r_gain);
        w_mag   = n_up ? (i_goal - r_gain) : (r_gain - i_goal);
        n_prod  = msm_pkg::GPROD_BITS'(w_mag) * msm_pkg::GPROD_BITS'(i_coeff);
        w_round = r_prod + msm_pkg::GAIN_HALF;
        w_step  = w_round[msm_pkg::COEFF_BITS-1 +: msm_pkg::GAIN_BITS];
        n_gain  = r_up ? (r_gain + w_step) : (r_gain - w_step);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.gain_mul) begin
            r_prod <= n_prod;
            r_up   <= n_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= msm_pkg::GAIN_RESET;
        end else if (i_ctl.gain_upd) begin
            r_gain <= n_gain;
        end
    end

    assign o_gain = r_gain;

endmodule

`default_nettype wire

/* hdl/msm_mix_lane.sv */
`default_nettype none

module msm_mix_lane (
    input  wire logic               i_clk,
    input  wire msm_pkg::t_step_ctl i_ctl,
    input  wire msm_pkg::t_sample   i_chat,
    input  wire msm_pkg::t_sample   i_mic,
    input  wire msm_pkg::t_gain     i_pri_gain,
    input  wire msm_pkg::t_gain     i_sec_gain,
    output msm_pkg::t_sample        o_mix,
    output logic                    o_clip
);

    logic signed [msm_pkg::MPROD_BITS-1:0] r_pa, n_pa, r_pb, n_pb;
    logic signed [msm_pkg::MSUM_BITS-1:0]  w_sum, w_rnd, w_y;
    logic                                  w_over, w_under;
    msm_pkg::t_sample                      r_y, n_y;
    logic                                  r_clip, n_clip;

    always_comb begin
        n_pa    = msm_pkg::MPROD_BITS'(i_chat) *
                  msm_pkg::MPROD_BITS'($signed({1'b0, i_pri_gain}));
        n_pb    = msm_pkg::MPROD_BITS'(i_mic) *
                  msm_pkg::MPROD_BITS'($signed({1'b0, i_sec_gain}));
        w_sum   = msm_pkg::MSUM_BITS'(r_pa) + msm_pkg::MSUM_BITS'(r_pb);
        w_rnd   = w_sum + msm_pkg::MIX_HALF;
        w_y     = w_rnd >>> msm_pkg::GAIN_FRAC;
        w_over  = (w_y > msm_pkg::MIX_MAX);
        w_under = (w_y < msm_pkg::MIX_MIN);
        if (w_over) begin
            n_y = msm_pkg::SAMPLE_BITS'(msm_pkg::MIX_MAX);
        end else if (w_under) begin
            n_y = msm_pkg::SAMPLE_BITS'(msm_pkg::MIX_MIN);
        end else begin
            n_y = w_y[msm_pkg::SAMPLE_BITS-1:0];
        end
        n_clip = w_over | w_under;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mix_mul) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_ctl.mix_sum) begin
            r_y    <= n_y;
            r_clip <= n_clip;
        end
    end

    assign o_mix  = r_y;
    assign o_clip = r_clip;

endmodule

`default_nettype wire

/* hdl/msm_merge.sv */
`default_nettype none

module msm_merge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire msm_pkg::t_step_ctl i_ctl,
    input  wire logic               i_take,
    input  wire msm_pkg::t_sample   i_left,
    input  wire msm_pkg::t_sample   i_right,
    input  wire logic               i_clip_left,
    input  wire logic               i_clip_right,
    input  wire logic               i_last,
    output logic                    o_valid,
    output logic [msm_pkg::OUT_DATA_BITS-1:0] o_data,
    output logic                    o_last
);

    logic [msm_pkg::CNT_BITS-1:0]   w_now;
    logic [msm_pkg::CLIP_BITS:0]    w_total;
    logic [msm_pkg::CLIP_BITS-1:0]  r_count, n_count;
    logic                           r_valid;
    logic [msm_pkg::OUT_DATA_BITS-1:0] r_data;
    logic                           r_last;

    always_comb begin
        w_now   = {1'b0, i_clip_left} + {1'b0, i_clip_right};
        w_total = {1'b0, r_count} + (msm_pkg::CLIP_BITS + 1)'(w_now);
        n_count = w_total[msm_pkg::CLIP_BITS] ? '1 : w_total[msm_pkg::CLIP_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.merge_load) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge_load) begin
            r_data <= msm_pkg::OUT_DATA_BITS'({n_count, w_now, i_right, i_left});
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

`default_nettype wire

/* hdl/two_source_stereo_mixer_top.sv */
// two-source stereo mixer: each input word carries a stereo frame from the chat and the mic
// source; every word first steps the two running gains one pole toward their goals, then
// mixes left and right in two lanes, rounds, clamps, and counts clipped channels. a word
// is taken when o_s_tready is high, which it is only while no word is in flight; the
// sequencer walks gain multiply, gain update, mix multiply, mix sum and merge, and a new
// word is taken only once merge has loaded the output register. that register holds a
// finished word until it is taken, and a new word can be taken meanwhile; the merge step
// waits if the previous word is still there. goals and coefficient are to be written over
// the apb port between words by the user; the block itself does not enforce it.
`default_nettype none

module two_source_stereo_mixer_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // chat_sample_left, chat_sample_right, mic_sample_left, mic_sample_right
    input  wire logic [msm_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // mix_left, mix_right, clipped_now, clipped_total, zero fill
    output logic [msm_pkg::OUT_DATA_BITS-1:0]       o_m_tdata,
    output logic                                    o_m_tlast,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [msm_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [msm_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [msm_pkg::CFG_DATA_BITS-1:0]       prdata,
    output logic                                    pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GMUL  = 3'd1;
    localparam logic [2:0] ST_GUPD  = 3'd2;
    localparam logic [2:0] ST_MMUL  = 3'd3;
    localparam logic [2:0] ST_MSUM  = 3'd4;
    localparam logic [2:0] ST_MERGE = 3'd5;

    localparam int SB = msm_pkg::SAMPLE_BITS;

    logic [2:0]         r_state, n_state;
    msm_pkg::t_step_ctl w_ctl;
    logic               w_accept, w_take, w_out_free;

    msm_pkg::t_sample   r_chat_l, r_chat_r, r_mic_l, r_mic_r;
    logic               r_last;

    msm_pkg::t_gain     r_pri_target, r_sec_target;
    msm_pkg::t_coeff    r_coeff, w_coeff;
    logic [1:0]         w_reg_idx;
    logic               w_cfg_wr;

    msm_pkg::t_gain     w_pri_gain, w_sec_gain;
    msm_pkg::t_sample   w_mix_l, w_mix_r;
    logic               w_clip_l, w_clip_r;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_take     = o_m_tvalid && i_m_tready;
    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_s_tvalid) n_state = ST_GMUL;
            ST_GMUL:  n_state = ST_GUPD;
            ST_GUPD:  n_state = ST_MMUL;
            ST_MMUL:  n_state = ST_MSUM;
            ST_MSUM:  n_state = ST_MERGE;
            ST_MERGE: if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.gain_mul   = (r_state == ST_GMUL);
        w_ctl.gain_upd   = (r_state == ST_GUPD);
        w_ctl.mix_mul    = (r_state == ST_MMUL);
        w_ctl.mix_sum    = (r_state == ST_MSUM);
        w_ctl.merge_load = (r_state == ST_MERGE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chat_l <= i_s_tdata[0*SB +: SB];
            r_chat_r <= i_s_tdata[1*SB +: SB];
            r_mic_l  <= i_s_tdata[2*SB +: SB];
            r_mic_r  <= i_s_tdata[3*SB +: SB];
            r_last   <= i_s_tlast;
        end
    end

    // config registers
    assign w_reg_idx = paddr[msm_pkg::ADDR_BITS-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_target <= msm_pkg::GAIN_RESET;
            r_sec_target <= msm_pkg::GAIN_RESET;
            r_coeff      <= msm_pkg::COEFF_ONE;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                msm_pkg::REG_PRI_TARGET: r_pri_target <= pwdata[msm_pkg::GAIN_BITS-1:0];
                msm_pkg::REG_SEC_TARGET: r_sec_target <= pwdata[msm_pkg::GAIN_BITS-1:0];
                msm_pkg::REG_COEFF:      r_coeff      <= pwdata[msm_pkg::COEFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            msm_pkg::REG_PRI_TARGET: prdata = msm_pkg::CFG_DATA_BITS'(r_pri_target);
            msm_pkg::REG_SEC_TARGET: prdata = msm_pkg::CFG_DATA_BITS'(r_sec_target);
            msm_pkg::REG_COEFF:      prdata = msm_pkg::CFG_DATA_BITS'(r_coeff);
            default:                 prdata = '0;
        endcase
    end

    // values above one act as one
    assign w_coeff = (r_coeff > msm_pkg::COEFF_ONE) ? msm_pkg::COEFF_ONE : r_coeff;

    msm_gain_lane u_pri_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_goal  (r_pri_target),
        .i_coeff (w_coeff),
        .o_gain  (w_pri_gain)
    );

    msm_gain_lane u_sec_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_goal  (r_sec_target),
        .i_coeff (w_coeff),
        .o_gain  (w_sec_gain)
    );

    msm_mix_lane u_mix_left (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_chat     (r_chat_l),
        .i_mic      (r_mic_l),
        .i_pri_gain (w_pri_gain),
        .i_sec_gain (w_sec_gain),
        .o_mix      (w_mix_l),
        .o_clip     (w_clip_l)
    );

    msm_mix_lane u_mix_right (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_chat     (r_chat_r),
        .i_mic      (r_mic_r),
        .i_pri_gain (w_pri_gain),
        .i_sec_gain (w_sec_gain),
        .o_mix      (w_mix_r),
        .o_clip     (w_clip_r)
    );

    msm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_take       (w_take),
        .i_left       (w_mix_l),
        .i_right      (w_mix_r),
        .i_clip_left  (w_clip_l),
        .i_clip_right (w_clip_r),
        .i_last       (r_last),
        .o_valid      (o_m_tvalid),
        .o_data       (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule

`default_nettype wire

/* hdl/msm_checker.sv */
`default_nettype none

module msm_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [msm_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    input wire logic                             o_m_tlast
);

    localparam int CN_LO = 2 * msm_pkg::SAMPLE_BITS;
    localparam int CT_LO = CN_LO + msm_pkg::CNT_BITS;

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not empty after reset");

    // one word in flight at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a word is in flight");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // a clip in this word shows in the running total
    a_clip_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[CN_LO +: msm_pkg::CNT_BITS] != '0)
        |-> (o_m_tdata[CT_LO +: msm_pkg::CLIP_BITS] != '0) &&
            (o_m_tdata[CN_LO +: msm_pkg::CNT_BITS] != 2'b11))
        else $error("clip count inconsistent");

endmodule

bind two_source_stereo_mixer_top msm_checker u_msm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

/* tb/tb_two_source_stereo_mixer_top.sv */
`timescale 1ns / 1ps

module tb_two_source_stereo_mixer_top;

    import msm_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam longint LANE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint LANE_MIN = -LANE_MAX - 1;
    localparam t_sample S_MAX = t_sample'(LANE_MAX);
    localparam t_sample S_MIN = t_sample'(LANE_MIN);
    localparam t_sample S_HALF = t_sample'(longint'(1) << (SAMPLE_BITS - 2));

    typedef struct {
        logic [IN_DATA_BITS-1:0] data;
        logic                    last;
    } t_frame;

    typedef struct {
        t_sample             left;
        t_sample             right;
        logic [CNT_BITS-1:0] now;
        logic [CLIP_BITS-1:0] total;
        logic                done;
    } t_mix_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    // chat_sample_left, chat_sample_right, mic_sample_left, mic_sample_right
    logic [IN_DATA_BITS-1:0]    i_s_tdata = '0;
    logic                       i_s_tlast = 1'b0;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    // mix_left, mix_right, clipped_now, clipped_total, zero fill
    logic [OUT_DATA_BITS-1:0]   o_m_tdata;
    logic                       o_m_tlast;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_BITS-1:0]       paddr = '0;
    logic [CFG_DATA_BITS-1:0]   pwdata = '0;
    logic [CFG_DATA_BITS-1:0]   prdata;
    logic                       pready;

    two_source_stereo_mixer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    t_frame    frame_q[$];
    t_mix_word mix_expect_q[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        mismatches = 0;

    // mixer state as the block should hold it
    t_gain             pri_target = GAIN_RESET;
    t_gain             sec_target = GAIN_RESET;
    t_coeff            glide_coeff = COEFF_ONE;
    t_gain             pri_gain = GAIN_RESET;
    t_gain             sec_gain = GAIN_RESET;
    logic [CLIP_BITS-1:0] clip_total = '0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic t_gain gain_glide(input t_gain cur, input t_gain goal, input t_coeff c);
        longint unsigned mag;
        longint unsigned stp;
        if (goal >= cur) begin
            mag = goal - cur;
            stp = (mag * c + (64'd1 << 23)) >> 24;
            return t_gain'(cur + stp);
        end
        mag = cur - goal;
        stp = (mag * c + (64'd1 << 23)) >> 24;
        return t_gain'(cur - stp);
    endfunction

    function automatic t_sample mix_lane(input t_sample a, input t_sample b,
                                         inout logic [CNT_BITS-1:0] clips);
        longint s;
        longint r;
        s = longint'(a) * longint'(pri_gain) + longint'(b) * longint'(sec_gain);
        r = (s + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (r > LANE_MAX) begin
            r = LANE_MAX;
            clips++;
        end else if (r < LANE_MIN) begin
            r = LANE_MIN;
            clips++;
        end
        return t_sample'(r);
    endfunction

    function automatic t_mix_word mixer_step(input logic [IN_DATA_BITS-1:0] d, input logic last);
        t_mix_word w;
        t_coeff c;
        logic [CNT_BITS-1:0] clips;
        c = (glide_coeff > COEFF_ONE) ? COEFF_ONE : glide_coeff;
        pri_gain = gain_glide(pri_gain, pri_target, c);
        sec_gain = gain_glide(sec_gain, sec_target, c);
        clips = '0;
        w.left = mix_lane(d[0 +: SAMPLE_BITS], d[2*SAMPLE_BITS +: SAMPLE_BITS], clips);
        w.right = mix_lane(d[SAMPLE_BITS +: SAMPLE_BITS], d[3*SAMPLE_BITS +: SAMPLE_BITS], clips);
        if ('1 - clip_total < CLIP_BITS'(clips))
            clip_total = '1;
        else
            clip_total = clip_total + CLIP_BITS'(clips);
        w.now = clips;
        w.total = clip_total;
        w.done = last;
        return w;
    endfunction

    // driver
    always @(posedge i_clk) begin : frame_driver
        t_frame f;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                mix_expect_q.push_back(mixer_step(i_s_tdata, i_s_tlast));
            if (!i_s_tvalid || o_s_tready) begin
                if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    f = frame_q.pop_front();
                    i_s_tdata <= f.data;
                    i_s_tlast <= f.last;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mix_monitor
        t_mix_word w;
        t_sample got_l;
        t_sample got_r;
        logic [CNT_BITS-1:0] got_now;
        logic [CLIP_BITS-1:0] got_total;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_l = o_m_tdata[0 +: SAMPLE_BITS];
            got_r = o_m_tdata[SAMPLE_BITS +: SAMPLE_BITS];
            got_now = o_m_tdata[2*SAMPLE_BITS +: CNT_BITS];
            got_total = o_m_tdata[2*SAMPLE_BITS+CNT_BITS +: CLIP_BITS];
            if (mix_expect_q.size() == 0) begin
                report_mismatch($sformatf("output word with nothing expected, data %h",
                                          o_m_tdata));
            end else begin
                w = mix_expect_q.pop_front();
                if (got_l !== w.left)
                    report_mismatch($sformatf("mix_left %h, expected %h", got_l, w.left));
                if (got_r !== w.right)
                    report_mismatch($sformatf("mix_right %h, expected %h", got_r, w.right));
                if (got_now !== w.now)
                    report_mismatch($sformatf("clipped_now %0d, expected %0d", got_now, w.now));
                if (got_total !== w.total)
                    report_mismatch($sformatf("clipped_total %0d, expected %0d",
                                              got_total, w.total));
                if (o_m_tlast !== w.done)
                    report_mismatch($sformatf("block_done %b, expected %b", o_m_tlast, w.done));
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_frame make_frame(input t_sample cl, input t_sample cr,
                                          input t_sample ml, input t_sample mr,
                                          input logic last);
        t_frame f;
        f.data = {mr, ml, cr, cl};
        f.last = last;
        return f;
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            2: return t_sample'(int'($urandom_range(0, 511)) - 256);
            3: return t_sample'(int'($urandom_range(0, 2 * S_HALF)) - S_HALF);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n)
            frame_q.push_back(make_frame(rand_sample(), rand_sample(), rand_sample(),
                                         rand_sample(), $urandom_range(7) == 0));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (frame_q.size() != 0 || i_s_tvalid || mix_expect_q.size() != 0);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PRI_TARGET: pri_target = t_gain'(value);
            REG_SEC_TARGET: sec_target = t_gain'(value);
            REG_COEFF:      glide_coeff = t_coeff'(value);
            default: ;
        endcase
    endtask

    task automatic set_mix(input logic [CFG_DATA_BITS-1:0] chat_g,
                           input logic [CFG_DATA_BITS-1:0] mic_g,
                           input logic [CFG_DATA_BITS-1:0] c);
        wait_drained();
        repeat (8) @(posedge i_clk);
        apb_write(REG_PRI_TARGET, chat_g);
        apb_write(REG_SEC_TARGET, mic_g);
        apb_write(REG_COEFF, c);
        apb_write(REG_SPARE, $urandom);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] rand_goal();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(0, 1 << (GAIN_FRAC + 1));
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_coeff();
        case ($urandom_range(5))
            0: return '0;
            1: return CFG_DATA_BITS'(COEFF_ONE);
            2: return $urandom_range(1, 1 << 18);
            3: return CFG_DATA_BITS'(COEFF_ONE) + $urandom_range(1, (1 << 24) - 1);
            default: return $urandom_range(0, 1 << 24);
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // unity gains after reset
        frame_q.push_back(make_frame('0, '0, '0, '0, 1'b0));
        frame_q.push_back(make_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b0));
        frame_q.push_back(make_frame(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1));
        frame_q.push_back(make_frame(S_HALF, S_HALF, S_HALF, S_HALF, 1'b0));
        frame_q.push_back(make_frame(-S_HALF, -S_HALF, -S_HALF, -S_HALF, 1'b0));
        frame_q.push_back(make_frame(S_MAX, S_MIN, '0, '0, 1'b1));
        frame_q.push_back(make_frame(S_MAX, 24'sd1, S_MIN, -24'sd1, 1'b0));
        frame_q.push_back(make_frame(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 1'b1));
        frame_q.push_back(make_frame(S_MAX, S_MAX, 24'sd1, -24'sd1, 1'b0));

        // extreme goals, wide writes, coefficient above one
        set_mix(32'hFFFF_FFFF, 32'hFF00_0000, 32'hFFFF_FFFF);
        frame_q.push_back(make_frame(24'sd1, -24'sd1, S_MAX, S_MIN, 1'b0));
        frame_q.push_back(make_frame(24'sd65536, -24'sd65536, '0, '0, 1'b1));
        frame_q.push_back(make_frame(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0));
        frame_q.push_back(make_frame(24'sd524288, -24'sd524288, '0, '0, 1'b0));

        // frozen gains: goals move, coefficient zero
        set_mix(32'h0008_0000, 32'h00F0_0000, 32'h0);
        frame_q.push_back(make_frame(24'sd1000, -24'sd1000, S_MAX, S_MIN, 1'b0));
        frame_q.push_back(make_frame(S_HALF, -S_HALF, '0, '0, 1'b1));

        // half-way glide toward new goals
        set_mix(32'h0010_0000, 32'h0000_0000, 32'h0080_0000);
        repeat (4)
            frame_q.push_back(make_frame(S_HALF, -S_HALF, S_MAX, S_MIN, 1'b0));
        frame_q.push_back(make_frame(24'sd3, -24'sd3, 24'sd7, -24'sd7, 1'b1));

        for (int ph = 0; ph < 8; ph++) begin
            set_mix(rand_goal(), rand_goal(), rand_coeff());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (ph == 3) begin
                push_random(55);
                wait_drained();
                push_random(60);
            end else begin
                push_random(115);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
